@@ design/cpos_pkg.sv @@
// shared types and constants for the calorimeter pile-up offset subtraction unit
package cpos_pkg;

  // field widths
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 13;
  localparam int ENERGY_W  = 24;
  localparam int OFFSET_W  = 20;
  localparam int QUAL_W    = 16;
  localparam int SCALE_W   = 13;
  localparam int OUT_OFF_W = 23;
  localparam int FACTOR_W  = 40;
  localparam int ROOT_W    = 28;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // command codes on in_tuser
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCALE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIGIT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALING_MIN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCALING_BIN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUB_EN      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MASK_EN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUAL_MASK   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_USE_SPD     = 3'd5;

  // occupancy correction constants
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 13'd6015;
  localparam logic [SCALE_W-1:0] NCELLS_OCC  = 13'd6016;
  localparam logic [SCALE_W-1:0] QUARTER_OCC = 13'd1504;
  localparam logic [12:0]        HALF_OCC    = 13'd3008;

  // one cell entry of the offset store
  typedef struct packed {
    logic                valid;
    logic [QUAL_W-1:0]   quality;
    logic [OFFSET_W-1:0] spd_offset;
    logic [OFFSET_W-1:0] offset;
  } cell_entry_t;

  // request to the scale unit
  typedef struct packed {
    logic               start;
    logic [SCALE_W-1:0] scale;
    logic [15:0]        min;
    logic [15:0]        bin;
  } scale_req_t;

  // scale unit sequencer
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_ROOT_C,
    SC_DIV_C,
    SC_DIV_F,
    SC_ROOT_F,
    SC_DONE
  } scale_st_t;

endpackage

@@ design/cpos_ram.sv @@
// generic single-port-write, registered-read memory
module cpos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ design/cpos_scale.sv @@
// scale factor unit: occupancy correction, divide and square root, one bit per cycle
module cpos_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cpos_pkg::scale_req_t          req,
  input  logic                          commit_ok,
  output logic                          busy,
  output logic [cpos_pkg::FACTOR_W-1:0] factor_r,
  output logic [cpos_pkg::ROOT_W-1:0]   root_r
);
  import cpos_pkg::*;

  localparam logic [41:0] CORR_BASE = 42'(64'd3008 << 16);

  scale_st_t state_r, state_nxt;
  logic [5:0]          cnt_r;
  logic [55:0]         work_r;
  logic [29:0]         rem_r;
  logic [27:0]         acc_r;
  logic [15:0]         div_r;
  logic [FACTOR_W-1:0] f_r;

  logic [SCALE_W-1:0] s_sat;
  logic               zero_case;
  logic               small_case;
  logic [12:0]        half_diff;
  logic [23:0]        t_val;
  logic [25:0]        num_prod;
  logic [15:0]        den_c;
  logic [15:0]        bin_eff;
  logic               last;

  logic [29:0] sq_rem2;
  logic [29:0] sq_trial;
  logic        sq_ge;
  logic [29:0] sq_rem_n;
  logic [27:0] sq_root_n;

  logic [16:0] dv_rem2;
  logic        dv_ge;
  logic [15:0] dv_rem_n;
  logic [41:0] dv_quot;

  logic [41:0]         corr;
  logic [41:0]         min_q;
  logic [41:0]         diff;
  logic [FACTOR_W-1:0] f_sat;

  // operand setup
  always_comb begin
    s_sat      = (req.scale > SCALE_MAX) ? SCALE_MAX : req.scale;
    zero_case  = (s_sat == '0) || ({3'b0, s_sat} <= req.min);
    small_case = s_sat < QUARTER_OCC;
    half_diff  = HALF_OCC - {s_sat[11:0], 1'b0};
    t_val      = 24'(HALF_OCC) * {11'b0, half_diff};
    num_prod   = 26'(s_sat) * 26'(NCELLS_OCC);
    den_c      = {3'b0, NCELLS_OCC - s_sat};
    bin_eff    = (req.bin == '0) ? 16'd1 : req.bin;
    last       = cnt_r == '0;
  end

  // square root step, two operand bits per cycle
  always_comb begin
    sq_rem2   = {rem_r[27:0], work_r[55:54]};
    sq_trial  = {acc_r, 2'b01};
    sq_ge     = sq_rem2 >= sq_trial;
    sq_rem_n  = sq_ge ? sq_rem2 - sq_trial : sq_rem2;
    sq_root_n = {acc_r[26:0], sq_ge};
  end

  // restoring divide step
  always_comb begin
    dv_rem2  = {rem_r[15:0], work_r[41]};
    dv_ge    = dv_rem2 >= {1'b0, div_r};
    dv_rem_n = dv_ge ? 16'(dv_rem2 - {1'b0, div_r}) : dv_rem2[15:0];
    dv_quot  = {work_r[40:0], dv_ge};
  end

  // corrected excess over the threshold, and saturated factor
  always_comb begin
    corr  = (state_r == SC_ROOT_C) ? CORR_BASE - {14'b0, sq_root_n} : dv_quot;
    min_q = {10'b0, req.min, 16'b0};
    diff  = (corr > min_q) ? corr - min_q : '0;
    f_sat = (dv_quot[41:40] != 2'b00) ? '1 : dv_quot[39:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: begin
        if (req.start) begin
          if (zero_case) state_nxt = SC_DONE;
          else if (small_case) state_nxt = SC_ROOT_C;
          else state_nxt = SC_DIV_C;
        end
      end
      SC_ROOT_C, SC_DIV_C: if (last) state_nxt = SC_DIV_F;
      SC_DIV_F: if (last) state_nxt = SC_ROOT_F;
      SC_ROOT_F: if (last) state_nxt = SC_DONE;
      SC_DONE: if (commit_ok) state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = state_r != SC_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      SC_IDLE: begin
        rem_r <= '0;
        acc_r <= '0;
        f_r   <= '0;
        if (small_case) begin
          work_r <= {t_val, 32'b0};
          cnt_r  <= 6'd27;
        end else begin
          work_r <= {14'b0, num_prod, 16'b0};
          div_r  <= den_c;
          cnt_r  <= 6'd41;
        end
      end
      SC_ROOT_C, SC_ROOT_F: begin
        rem_r  <= sq_rem_n;
        acc_r  <= sq_root_n;
        work_r <= {work_r[53:0], 2'b00};
        cnt_r  <= cnt_r - 6'd1;
        if (last && state_r == SC_ROOT_C) begin
          work_r <= {14'b0, diff};
          rem_r  <= '0;
          div_r  <= bin_eff;
          cnt_r  <= 6'd41;
        end
      end
      SC_DIV_C, SC_DIV_F: begin
        rem_r  <= {14'b0, dv_rem_n};
        work_r <= {work_r[54:0], dv_ge};
        cnt_r  <= cnt_r - 6'd1;
        if (last) begin
          rem_r <= '0;
          if (state_r == SC_DIV_C) begin
            work_r <= {14'b0, diff};
            div_r  <= bin_eff;
            cnt_r  <= 6'd41;
          end else begin
            f_r    <= f_sat;
            work_r <= {f_sat, 16'b0};
            acc_r  <= '0;
            cnt_r  <= 6'd27;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // published factor and root, swapped in from the done state once commit_ok is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= '0;
      root_r   <= '0;
    end else if (state_r == SC_DONE && commit_ok) begin
      factor_r <= f_r;
      root_r   <= acc_r;
    end
  end

endmodule

@@ design/calorimeter_pileup_offset_subtract_unit.sv @@
// top level: cell store, digit cleaning pipeline and configuration registers
//
// Load and digit transfers are taken one per cycle while in_tready is high. A digit's
// result is registered with the store read in stage one, with the products in stage
// two, and after the clamp in the output register behind out_tvalid. The pipeline only
// stalls when the output is back-pressured. A scale transfer runs through the shared
// bit-serial divide and square-root unit and holds off input while it works: below a
// quarter of the occupancy, 28 root steps for the occupancy correction, 42 for the bin
// divide and 28 for the root, then publishing; above it, 42 divide steps replace the 28
// for the correction. A scale at or below the threshold goes straight to publishing a zero
// factor. After reset the cell store is swept clear of valid entries, one cell per cycle
// over all CELL_COUNT cells, in_tready low; configuration writes are taken at any time.
module calorimeter_pileup_offset_subtract_unit #(
  parameter int CELL_COUNT = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // cell_index, energy_in, offset_ref, offset_spd_ref, quality_flags, entry_valid,
  // event_scale, zero fill
  input  logic [111:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // energy_out, offset_applied, offset_rms, zero fill
  output logic [71:0]  out_tdata,
  // was_masked
  output logic         out_tuser,
  // configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);
  import cpos_pkg::*;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ENTRY_W = $bits(cell_entry_t);

  // configuration registers
  logic [15:0]     scaling_min_r;
  logic [15:0]     scaling_bin_r;
  logic            sub_en_r;
  logic            mask_en_r;
  logic [QUAL_W-1:0] qual_mask_r;
  logic            use_spd_r;

  // input field unpacking
  logic [IDX_W-1:0]    in_idx;
  logic [ENERGY_W-1:0] in_energy;
  logic [OFFSET_W-1:0] in_off;
  logic [OFFSET_W-1:0] in_spd;
  logic [QUAL_W-1:0]   in_qual;
  logic                in_valid_bit;
  logic [SCALE_W-1:0]  in_scale;
  logic                in_inside;

  // clearing sweep
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // pipeline control
  logic adv;
  logic accept;
  logic scale_busy;

  // store access
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cell_entry_t       ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  cell_entry_t       rd_entry;

  // scale unit
  scale_req_t          sreq;
  logic [FACTOR_W-1:0] factor;
  logic [ROOT_W-1:0]   root;

  // stage one: store read in flight
  logic                s1_v_r;
  logic [ENERGY_W-1:0] s1_energy_r;
  logic                s1_inside_r;

  // stage two: products
  logic                s2_v_r;
  logic [ENERGY_W-1:0] s2_energy_r;
  logic                s2_masked_r;
  logic                s2_sub_r;
  logic [59:0]         s2_pf_r;
  logic [47:0]         s2_pr_r;

  logic [QUAL_W-1:0]   s1_qual;
  logic                s1_valid;
  logic                s1_masked;
  logic [OFFSET_W-1:0] s1_ref;

  logic [43:0]         off_full;
  logic [31:0]         rms_full;
  logic [45:0]         diff_e;
  logic [ENERGY_W-1:0] e_nxt;
  logic [OUT_OFF_W-1:0] applied_nxt;
  logic [OUT_OFF_W-1:0] rms_nxt;

  // output register
  logic                 out_valid_r;
  logic [ENERGY_W-1:0]  out_energy_r;
  logic                 out_masked_r;
  logic [OUT_OFF_W-1:0] out_applied_r;
  logic [OUT_OFF_W-1:0] out_rms_r;

  // field unpacking
  always_comb begin
    in_idx       = in_tdata[12:0];
    in_energy    = in_tdata[36:13];
    in_off       = in_tdata[56:37];
    in_spd       = in_tdata[76:57];
    in_qual      = in_tdata[92:77];
    in_valid_bit = in_tdata[93];
    in_scale     = in_tdata[106:94];
    in_inside    = 32'(in_idx) < 32'(CELL_COUNT);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaling_min_r <= 16'd150;
      scaling_bin_r <= 16'd50;
      sub_en_r      <= 1'b1;
      mask_en_r     <= 1'b1;
      qual_mask_r   <= '0;
      use_spd_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCALING_MIN: scaling_min_r <= cfg_wdata;
        CFG_SCALING_BIN: scaling_bin_r <= cfg_wdata;
        CFG_SUB_EN:      sub_en_r      <= cfg_wdata[0];
        CFG_MASK_EN:     mask_en_r     <= cfg_wdata[0];
        CFG_QUAL_MASK:   qual_mask_r   <= cfg_wdata;
        CFG_USE_SPD:     use_spd_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  always_comb begin
    adv       = !out_valid_r || out_tready;
    in_tready = adv && !clr_active_r && !scale_busy;
    accept    = in_tvalid && in_tready;
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(CELL_COUNT - 1)) clr_active_r <= 1'b0;
    end
  end

  // store write: sweep or load transfer
  always_comb begin
    ram_wdata.valid      = in_valid_bit;
    ram_wdata.quality    = in_qual;
    ram_wdata.spd_offset = in_spd;
    ram_wdata.offset     = in_off;
    ram_waddr            = ADDR_W'(in_idx);
    ram_we               = accept && in_tuser == CMD_LOAD && in_inside;
    if (clr_active_r) begin
      ram_wdata = '0;
      ram_waddr = clr_addr_r;
      ram_we    = 1'b1;
    end
  end

  cpos_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CELL_COUNT)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (adv),
    .raddr  (ADDR_W'(in_idx)),
    .rdata_r(ram_rdata)
  );

  assign rd_entry = cell_entry_t'(ram_rdata);

  // scale unit, factor swapped only when no digit waits for its products
  always_comb begin
    sreq.start = accept && in_tuser == CMD_SCALE;
    sreq.scale = in_scale;
    sreq.min   = scaling_min_r;
    sreq.bin   = scaling_bin_r;
  end

  cpos_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sreq),
    .commit_ok(!s1_v_r),
    .busy     (scale_busy),
    .factor_r (factor),
    .root_r   (root)
  );

  // stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept && in_tuser == CMD_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_energy_r <= in_energy;
      s1_inside_r <= in_inside;
    end
  end

  // masking and offset selection
  always_comb begin
    s1_qual   = s1_inside_r ? rd_entry.quality : '0;
    s1_valid  = s1_inside_r && rd_entry.valid;
    s1_masked = mask_en_r && qual_mask_r != '0 && (s1_qual & qual_mask_r) != '0;
    s1_ref    = use_spd_r ? rd_entry.spd_offset : rd_entry.offset;
  end

  // stage two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_energy_r <= s1_masked ? '0 : s1_energy_r;
      s2_masked_r <= s1_masked;
      s2_sub_r    <= sub_en_r && s1_valid;
      s2_pf_r     <= 60'(factor) * 60'(s1_ref);
      s2_pr_r     <= 48'(root) * 48'(s1_ref);
    end
  end

  // subtraction with clamp at zero, saturation of reported offsets
  always_comb begin
    off_full    = s2_pf_r[59:16];
    rms_full    = s2_pr_r[47:16];
    diff_e      = {{22{s2_energy_r[23]}}, s2_energy_r} - {2'b00, off_full};
    e_nxt       = s2_energy_r;
    applied_nxt = '0;
    rms_nxt     = '0;
    if (s2_sub_r) begin
      if (off_full != '0) e_nxt = diff_e[45] ? '0 : diff_e[23:0];
      applied_nxt = (off_full[43:23] != '0) ? '1 : off_full[22:0];
      rms_nxt     = (rms_full[31:23] != '0) ? '1 : rms_full[22:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_energy_r  <= e_nxt;
      out_masked_r  <= s2_masked_r;
      out_applied_r <= applied_nxt;
      out_rms_r     <= rms_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rms_r, out_applied_r, out_energy_r};
  assign out_tuser  = out_masked_r;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the calorimeter pile-up offset subtraction unit
`timescale 1ns / 100ps

module testbench;
  import cpos_pkg::*;

  // one input transfer, unpacked
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    cell_idx;
    logic [ENERGY_W-1:0] energy;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] spd_offset;
    logic [QUAL_W-1:0]   quality;
    logic                entry_valid;
    logic [SCALE_W-1:0]  scale;
  } cell_item_t;

  // one cleaned digit
  typedef struct {
    logic [ENERGY_W-1:0]  energy;
    logic                 masked;
    logic [OUT_OFF_W-1:0] applied;
    logic [OUT_OFF_W-1:0] rms;
  } clean_digit_t;

  localparam int NCELL = 8192;
  localparam int IDLE_LIMIT = 30000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;

  calorimeter_pileup_offset_subtract_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // stimulus and expectation stores
  cell_item_t   pending_items[$];
  clean_digit_t expected_digits[$];

  // predictor state
  logic [OFFSET_W-1:0] pred_offset[NCELL];
  logic [OFFSET_W-1:0] pred_spd[NCELL];
  logic [QUAL_W-1:0]   pred_quality[NCELL];
  logic                pred_valid[NCELL];
  longint unsigned     pred_factor, pred_root;
  // register shadow
  logic [15:0] sh_min = 16'd150, sh_bin = 16'd50, sh_qmask = 16'd0;
  logic        sh_sub = 1'b1, sh_mask = 1'b1, sh_spd = 1'b0;

  // generator bookkeeping: cells loaded so far
  bit  loaded[NCELL];
  int  loaded_cells[$];

  int  mismatches = 0;
  int  digits_seen = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  in_acc = 1'b0, out_acc = 1'b0;
  bit  gaps_on = 1'b1;
  int  send_gap = 0, recv_gap = 0;
  int  recv_hold = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // occupancy-corrected factor and its root
  function automatic void update_scale(logic [SCALE_W-1:0] raw);
    longint unsigned s, corr, minq, diff, bin, f, r;
    s = (raw > 6015) ? 6015 : raw;
    if (s == 0 || s <= sh_min) begin
      pred_factor = 0;
      pred_root = 0;
      return;
    end
    if (s < 1504)
      corr = (64'd3008 << 16) - int_sqrt((64'd3008 * (64'd3008 - 2 * s)) << 32);
    else
      corr = ((s * 64'd6016) << 16) / (64'd6016 - s);
    minq = longint'(sh_min) << 16;
    diff = (corr > minq) ? corr - minq : 0;
    bin = (sh_bin == 0) ? 1 : sh_bin;
    f = diff / bin;
    if (f > 64'hFF_FFFF_FFFF) f = 64'hFF_FFFF_FFFF;
    r = int_sqrt(f << 16);
    if (r > 64'hFFF_FFFF) r = 64'hFFF_FFFF;
    pred_factor = f;
    pred_root = r;
  endfunction

  // apply one accepted item to the predictor
  function automatic void predict_item(cell_item_t it);
    clean_digit_t d;
    longint signed e;
    longint unsigned ref_off, off, rms;
    if (it.cmd == CMD_LOAD) begin
      pred_offset[it.cell_idx]  = it.offset;
      pred_spd[it.cell_idx]     = it.spd_offset;
      pred_quality[it.cell_idx] = it.quality;
      pred_valid[it.cell_idx]   = it.entry_valid;
    end else if (it.cmd == CMD_SCALE) begin
      update_scale(it.scale);
    end else if (it.cmd == CMD_DIGIT) begin
      e = longint'(signed'(it.energy));
      d.masked = 1'b0;
      d.applied = '0;
      d.rms = '0;
      if (sh_mask && sh_qmask != 0 && (pred_quality[it.cell_idx] & sh_qmask) != 0) begin
        e = 0;
        d.masked = 1'b1;
      end
      if (sh_sub && pred_valid[it.cell_idx]) begin
        ref_off = sh_spd ? pred_spd[it.cell_idx] : pred_offset[it.cell_idx];
        off = (pred_factor * ref_off) >> 16;
        rms = (pred_root * ref_off) >> 16;
        if (off != 0) e = (e - longint'(off) < 0) ? 0 : e - longint'(off);
        d.applied = (off > 64'h7F_FFFF) ? 23'h7F_FFFF : off[22:0];
        d.rms = (rms > 64'h7F_FFFF) ? 23'h7F_FFFF : rms[22:0];
      end
      d.energy = e[23:0];
      expected_digits.push_back(d);
    end
  endfunction

  // input and output transfers, prediction and checking
  always @(posedge clk) begin
    clean_digit_t exp_d;
    in_acc = rst_n && in_tvalid && in_tready;
    out_acc = rst_n && out_tvalid && out_tready;
    if (in_acc) begin
      cell_item_t it;
      it.cmd = in_tuser;
      it.cell_idx = in_tdata[12:0];
      it.energy = in_tdata[36:13];
      it.offset = in_tdata[56:37];
      it.spd_offset = in_tdata[76:57];
      it.quality = in_tdata[92:77];
      it.entry_valid = in_tdata[93];
      it.scale = in_tdata[106:94];
      predict_item(it);
    end
    if (out_acc) begin
      digits_seen++;
      if (expected_digits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digit result %h", out_tdata);
      end else begin
        exp_d = expected_digits.pop_front();
        if (out_tdata[23:0] !== exp_d.energy || out_tuser !== exp_d.masked ||
            out_tdata[46:24] !== exp_d.applied || out_tdata[69:47] !== exp_d.rms) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digit mismatch: exp e=%h m=%b off=%h rms=%h got e=%h m=%b off=%h rms=%h",
                     exp_d.energy, exp_d.masked, exp_d.applied, exp_d.rms,
                     out_tdata[23:0], out_tuser, out_tdata[46:24], out_tdata[69:47]);
        end
      end
    end
    idle_cycles = (in_acc || out_acc) ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    cell_item_t it;
    bit drive;
    drive = in_tvalid && !in_acc;
    if (!drive && rst_n) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tuser <= it.cmd;
        in_tdata <= {5'b0, it.scale, it.entry_valid, it.quality, it.spd_offset,
                     it.offset, it.energy, it.cell_idx};
        items_sent++;
        drive = 1'b1;
        send_gap = gaps_on ? int'($urandom_range(0, 6)) : 0;
      end
    end
    in_tvalid <= drive;
  end

  // receiver
  always @(negedge clk) begin
    if (out_acc) recv_gap = gaps_on ? int'($urandom_range(0, 6)) : 0;
    if (recv_hold > 0) begin
      recv_hold--;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    case (addr)
      CFG_SCALING_MIN: sh_min = value;
      CFG_SCALING_BIN: sh_bin = value;
      CFG_SUB_EN:      sh_sub = value[0];
      CFG_MASK_EN:     sh_mask = value[0];
      CFG_QUAL_MASK:   sh_qmask = value;
      CFG_USE_SPD:     sh_spd = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] mn, logic [15:0] bn, bit sub, bit msk,
                           logic [15:0] qm, bit spd);
    write_reg(CFG_SCALING_MIN, mn);
    write_reg(CFG_SCALING_BIN, bn);
    write_reg(CFG_SUB_EN, {15'b0, sub});
    write_reg(CFG_MASK_EN, {15'b0, msk});
    write_reg(CFG_QUAL_MASK, qm);
    write_reg(CFG_USE_SPD, {15'b0, spd});
  endtask

  // wait until the block has drained, then cover a possible scale computation
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_digits.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic void push_load(logic [IDX_W-1:0] cell_idx, logic [OFFSET_W-1:0] off,
                                    logic [OFFSET_W-1:0] spd, logic [QUAL_W-1:0] q, bit v);
    cell_item_t it;
    it = '{CMD_LOAD, cell_idx, ENERGY_W'($urandom()), off, spd, q, v,
           SCALE_W'($urandom())};
    if (!loaded[cell_idx]) loaded_cells.push_back(int'(cell_idx));
    loaded[cell_idx] = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic void push_scale(logic [SCALE_W-1:0] s);
    cell_item_t it;
    it = '{CMD_SCALE, IDX_W'($urandom()), ENERGY_W'($urandom()), OFFSET_W'($urandom()),
           OFFSET_W'($urandom()), QUAL_W'($urandom()), 1'($urandom()), s};
    pending_items.push_back(it);
  endfunction

  function automatic void push_digit(logic [IDX_W-1:0] cell_idx, logic [ENERGY_W-1:0] e);
    cell_item_t it;
    it = '{CMD_DIGIT, cell_idx, e, OFFSET_W'($urandom()), OFFSET_W'($urandom()),
           QUAL_W'($urandom()), 1'($urandom()), SCALE_W'($urandom())};
    pending_items.push_back(it);
  endfunction

  function automatic logic [OFFSET_W-1:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return OFFSET_W'($urandom_range(0, 15));
      1: return OFFSET_W'($urandom_range(0, 4095));
      default: return OFFSET_W'($urandom());
    endcase
  endfunction

  // random mix: loads, occasional scales, digits on loaded cells, a little noise
  function automatic void push_random(int n);
    cell_item_t it;
    int k;
    logic [IDX_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 20 || loaded_cells.size() == 0) begin
        c = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom()) : IDX_W'($urandom_range(0, 63));
        push_load(c, rand_offset(), rand_offset(), QUAL_W'($urandom()),
                  $urandom_range(0, 3) != 0);
      end else if (k < 24) begin
        push_scale($urandom_range(0, 7) == 0 ? SCALE_W'($urandom())
                                             : SCALE_W'($urandom_range(0, 6015)));
      end else if (k < 26) begin
        it = '{2'd3, IDX_W'($urandom()), ENERGY_W'($urandom()), OFFSET_W'($urandom()),
               OFFSET_W'($urandom()), QUAL_W'($urandom()), 1'($urandom()),
               SCALE_W'($urandom())};
        pending_items.push_back(it);
      end else begin
        push_digit(IDX_W'(loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]),
                   ENERGY_W'($urandom()));
      end
    end
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and the special cases under reset settings
    push_load(13'd0, 20'h0, 20'h0, 16'h0000, 1'b1);
    push_load(13'd8191, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1);
    push_load(13'd5, 20'h00010, 20'h12345, 16'h0001, 1'b0);
    push_load(13'd7, 20'h00100, 20'h00200, 16'h8000, 1'b1);
    push_digit(13'd0, 24'h800000);
    push_digit(13'd8191, 24'h7FFFFF);
    push_scale(13'd6015);
    push_digit(13'd0, 24'hFFFFFF);
    push_digit(13'd8191, 24'h7FFFFF);
    push_digit(13'd5, 24'h000000);
    push_digit(13'd7, 24'h001000);
    push_scale(13'd8191);
    push_digit(13'd7, 24'h800000);
    push_scale(13'd1503);
    push_digit(13'd7, 24'h7FFFFF);
    push_scale(13'd1504);
    push_digit(13'd8191, 24'h000001);
    push_scale(13'd0);
    push_digit(13'd7, 24'h000100);
    pending_items.push_back('{2'd3, 13'h1FFF, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF,
                              1'b1, 13'h1FFF});
    push_scale(13'd151);
    push_digit(13'd7, 24'h000100);
    wait_drained();

    // extreme settings: zero min, unit bin, full mask, spd table
    write_all(16'd0, 16'd1, 1'b1, 1'b1, 16'hFFFF, 1'b1);
    push_scale(13'd6015);
    push_random(250);
    wait_drained();

    // top extremes with subtraction and masking off, zero bin
    write_all(16'hFFFF, 16'd0, 1'b0, 1'b0, 16'h0000, 1'b0);
    push_scale(13'd3000);
    push_random(200);
    wait_drained();

    // long receiver hold-off so the block fills up, gaps off
    write_all(16'd150, 16'd50, 1'b1, 1'b1, 16'h0003, 1'b0);
    gaps_on = 1'b0;
    push_scale(13'd2500);
    recv_hold = 400;
    push_random(250);
    wait_drained();
    gaps_on = 1'b1;

    // random settings
    for (int p = 0; p < 4; p++) begin
      write_all($urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 2000)),
                $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(1, 100)),
                $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), 16'($urandom()),
                1'($urandom_range(0, 1)));
      push_scale(SCALE_W'($urandom_range(0, 6015)));
      push_random(250);
      wait_drained();
    end

    $display("covered %0d input transfers and %0d cleaned digits over 8 register settings",
             items_sent, digits_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_digits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
